// ===== rtl/core/cbnh_pkg.sv =====
// Shared types, constants and rounding helpers for the cubic Bezier near-hit tester.
// No dependencies; imported by every module of the block.
package cbnh_pkg;

	localparam int COORD_W = 16;   // Q12.4 coordinates
	localparam int PARAM_F = 16;   // fraction bits of t
	localparam int PARAM_W = PARAM_F + 1;
	localparam int CURVE_W = COORD_W + 2;
	localparam int WGT_W   = PARAM_W + 1;
	localparam int MUL_W   = COORD_W + 3;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int DIST_W  = 2 * CURVE_W - 1;
	localparam int DIVD_W  = DIST_W;
	localparam int DIVS_W  = 32;
	localparam int CFG_W   = 32;
	localparam int MARGIN_W = 12;
	localparam int RADIUS_W = 24;
	localparam int MINIT_W  = 7;

	localparam logic [PARAM_W-1:0] T_ONE  = PARAM_W'(1) << PARAM_F;
	localparam logic [PROD_W-1:0]  T_HALF = PROD_W'(1) << (PARAM_F - 1);

	typedef enum logic [1:0] {
		REG_BOUND_MARGIN = 2'd0,
		REG_HIT_RADIUS   = 2'd1,
		REG_ITER_DIV     = 2'd2,
		REG_MIN_ITER     = 2'd3
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t query_x;
		coord_t query_y;
		coord_t start_x;
		coord_t start_y;
		coord_t ctrl0_x;
		coord_t ctrl0_y;
		coord_t ctrl1_x;
		coord_t ctrl1_y;
		coord_t end_x;
		coord_t end_y;
	} cbnh_query_t;

	typedef struct packed {
		logic               is_near;
		logic               box_rejected;
		logic [PARAM_W-1:0] best_param;
		coord_t             closest_x;
		coord_t             closest_y;
	} cbnh_result_t;

	// round half up of an unsigned Q.2F product back to Q1.F
	function automatic logic [PARAM_W-1:0] rnd_u(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] s;
		s = $unsigned(p) + T_HALF;
		return s[PARAM_F +: PARAM_W];
	endfunction

	// round half up (floor of x + half) of a signed sum back to Q14.4
	function automatic logic signed [CURVE_W-1:0] rnd_s(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] s;
		s = a + $signed({{(ACC_W-PROD_W){1'b0}}, T_HALF});
		return s[PARAM_F +: CURVE_W];
	endfunction

	function automatic coord_t sat_coord(input logic signed [CURVE_W-1:0] v);
		localparam logic signed [CURVE_W-1:0] CMAX = CURVE_W'((1 << (COORD_W - 1)) - 1);
		localparam logic signed [CURVE_W-1:0] CMIN = -CMAX - CURVE_W'(1);
		if (v > CMAX) return CMAX[COORD_W-1:0];
		if (v < CMIN) return CMIN[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

endpackage

// ===== rtl/core/cbnh_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is a parameter; types come from cbnh_pkg.
interface cbnh_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/cbnh_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on cbnh_pkg for operand widths.
module cbnh_mul import cbnh_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod
);
	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule

// ===== rtl/core/cbnh_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the round count.
// Depends on cbnh_pkg for operand widths.
module cbnh_div import cbnh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DIVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/core/cubic_bezier_near_hit_test.sv =====
// Cubic Bezier near-hit tester: sequencer around one shared multiplier and one divider.
// Depends on cbnh_pkg, cbnh_stream_if, cbnh_mul and cbnh_div.
// On box rejection the result is emitted without curve evaluation; else a round-count
// division sets R rounds (R <= MAX_ITER) of SAMPLE_SLICES+1 curve samples each.
// Ready only when idle, so one query is processed at a time; results wait in out_q.
// Reset: configuration registers take their default values, sequencer returns to idle.
module cubic_bezier_near_hit_test import cbnh_pkg::*; #(
	parameter int SAMPLE_SLICES = 4,
	parameter int MAX_ITER      = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cbnh_stream_if.sink          query_in,
	cbnh_stream_if.source        result_out,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam int K_W  = $clog2(SAMPLE_SLICES + 1);
	localparam int FR_W = $clog2(2 * SAMPLE_SLICES);
	localparam int R_W  = $clog2(MAX_ITER + 1);
	localparam int RECIP = (1 << PARAM_W) / SAMPLE_SLICES;

	typedef enum logic [3:0] {
		S_IDLE, S_BOX, S_DIST, S_NEXT, S_EP_DIV, S_ROUND, S_W_DIV, S_EVAL, S_EMIT
	} state_t;

	typedef enum logic [1:0] {PH_EP, PH_SAMPLE, PH_FINAL} phase_t;

	// configuration
	logic [MARGIN_W-1:0] margin_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [DIVS_W-1:0]   iter_div_q;
	logic [MINIT_W-1:0]  min_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q   <= MARGIN_W'(64);
			radius_q   <= RADIUS_W'(9216);
			iter_div_q <= DIVS_W'(33177600);
			min_iter_q <= MINIT_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_BOUND_MARGIN: margin_q   <= cfg_data[MARGIN_W-1:0];
				REG_HIT_RADIUS:   radius_q   <= cfg_data[RADIUS_W-1:0];
				REG_ITER_DIV:     iter_div_q <= cfg_data[DIVS_W-1:0];
				REG_MIN_ITER:     min_iter_q <= cfg_data[MINIT_W-1:0];
				default: ;
			endcase
		end
	end

	state_t state_q;
	phase_t phase_q;

	coord_t pt_x_q [4];
	coord_t pt_y_q [4];
	coord_t qx_q, qy_q;

	logic [PARAM_W-1:0] t_q, uu_q, tt_q;
	logic [WGT_W-1:0]   b_q [4];
	logic signed [ACC_W-1:0]   accx_q, accy_q;
	logic signed [CURVE_W-1:0] cx_q, cy_q;
	logic signed [MUL_W-1:0]   dx_q, dy_q;
	logic [DIST_W-1:0]  d_q, best_d_q;
	logic [3:0]         step_q;
	logic [1:0]         dstep_q;
	logic [PARAM_W-1:0] lo_q, hi_q, tick_q, off_q, best_t_q;
	logic [FR_W-1:0]    remv_q, frac_q;
	logic [K_W-1:0]     k_q;
	logic [R_W-1:0]     r_q, rounds_q;
	logic               rejected_q;

	cbnh_result_t out_q;
	logic         out_valid_q;

	// shared units
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic              div_start, div_done;
	logic [DIVD_W-1:0] div_dvd, div_quo;
	logic [DIVS_W-1:0] div_dvs;

	cbnh_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	cbnh_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_quo)
	);

	logic [PARAM_W-1:0] u_val;
	logic [1:0]         pidx;
	assign u_val = T_ONE - t_q;
	assign pidx  = step_q[1:0] - 2'd2;

	function automatic logic signed [MUL_W-1:0] ext_u(input logic [PARAM_W-1:0] v);
		return $signed({{(MUL_W-PARAM_W){1'b0}}, v});
	endfunction

	function automatic logic signed [MUL_W-1:0] ext_c(input coord_t v);
		return {{(MUL_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_EVAL) begin
			unique case (step_q)
				4'd0: begin mul_a = ext_u(u_val); mul_b = ext_u(u_val); end
				4'd1: begin mul_a = ext_u(t_q);   mul_b = ext_u(t_q);   end
				4'd2: begin mul_a = ext_u(uu_q);  mul_b = ext_u(u_val); end
				4'd3: begin mul_a = ext_u(uu_q);  mul_b = ext_u(t_q);   end
				4'd4: begin mul_a = ext_u(u_val); mul_b = ext_u(tt_q);  end
				4'd5: begin mul_a = ext_u(tt_q);  mul_b = ext_u(t_q);   end
				4'd6, 4'd7, 4'd8, 4'd9: begin
					mul_a = $signed({1'b0, b_q[pidx]});
					mul_b = ext_c(pt_x_q[pidx]);
				end
				4'd10, 4'd11, 4'd12, 4'd13: begin
					mul_a = $signed({1'b0, b_q[pidx]});
					mul_b = ext_c(pt_y_q[pidx]);
				end
				default: ;
			endcase
		end else if (state_q == S_DIST) begin
			if (dstep_q == 2'd1) begin
				mul_a = dx_q;
				mul_b = dx_q;
			end else if (dstep_q == 2'd2) begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
		end
	end

	// divider request: round count from the end point distance
	assign div_start = (state_q == S_NEXT && phase_q == PH_EP);
	assign div_dvd   = d_q;
	assign div_dvs   = iter_div_q;

	// step size: reciprocal estimate, then one compare and subtract
	logic [PARAM_W-1:0]   w_val;
	logic [2*PARAM_W-1:0] w_scaled;
	logic [PARAM_W-1:0]   tick_sx, rem_full, rem_fix;
	logic                 tick_fix;
	assign w_val    = hi_q - lo_q;
	assign w_scaled = {{PARAM_W{1'b0}}, w_val} * (2*PARAM_W)'(RECIP);
	assign tick_sx  = tick_q * PARAM_W'(SAMPLE_SLICES);
	assign rem_full = w_val - tick_sx;
	assign tick_fix = rem_full >= PARAM_W'(SAMPLE_SLICES);
	assign rem_fix  = tick_fix ? rem_full - PARAM_W'(SAMPLE_SLICES) : rem_full;

	// round count
	logic [DIVD_W-1:0] q_min;
	logic [R_W-1:0]    rounds_n;
	always_comb begin
		q_min = (div_quo < DIVD_W'(min_iter_q)) ? DIVD_W'(min_iter_q) : div_quo;
		rounds_n = (q_min > DIVD_W'(MAX_ITER)) ? R_W'(MAX_ITER) : q_min[R_W-1:0];
	end

	// box test
	logic signed [CURVE_W-1:0] mrg, qxe, qye, p0x, p0y, p3x, p3y;
	logic reject;
	always_comb begin
		mrg = $signed({{(CURVE_W-MARGIN_W){1'b0}}, margin_q});
		qxe = CURVE_W'(qx_q);
		qye = CURVE_W'(qy_q);
		p0x = CURVE_W'(pt_x_q[0]);
		p0y = CURVE_W'(pt_y_q[0]);
		p3x = CURVE_W'(pt_x_q[3]);
		p3y = CURVE_W'(pt_y_q[3]);
		reject = (qxe < p0x - mrg && qxe < p3x - mrg) ||
			(qxe > p0x + mrg && qxe > p3x + mrg) ||
			(qye < p0y - mrg && qye < p3y - mrg) ||
			(qye > p0y + mrg && qye > p3y + mrg);
	end

	// sample bookkeeping
	logic [FR_W-1:0]    frac_sum, frac_n;
	logic               carry;
	logic [PARAM_W-1:0] off_n, best_t_n;
	logic [DIST_W-1:0]  best_d_n;
	logic [PARAM_W:0]   hi_sum, fin_sum;
	logic [PARAM_W-1:0] lo_n, hi_n;
	always_comb begin
		frac_sum = frac_q + remv_q;
		carry    = frac_sum >= FR_W'(SAMPLE_SLICES);
		frac_n   = carry ? frac_sum - FR_W'(SAMPLE_SLICES) : frac_sum;
		off_n    = off_q + tick_q + PARAM_W'(carry);
		if (k_q == '0 || d_q < best_d_q) begin
			best_t_n = t_q;
			best_d_n = d_q;
		end else begin
			best_t_n = best_t_q;
			best_d_n = best_d_q;
		end
		lo_n   = (best_t_n > tick_q) ? best_t_n - tick_q : '0;
		hi_sum = {1'b0, best_t_n} + {1'b0, tick_q};
		hi_n   = (hi_sum > {1'b0, T_ONE}) ? T_ONE : hi_sum[PARAM_W-1:0];
		fin_sum = {1'b0, lo_q} + {1'b0, hi_q};
	end

	logic signed [ACC_W-1:0] prod_e;
	logic [WGT_W-1:0]        w3;
	logic [PARAM_W-1:0]      prnd;
	assign prod_e = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign prnd   = rnd_u(prod);
	assign w3     = {prnd, 1'b0} + {1'b0, prnd};

	logic signed [CURVE_W-1:0] ax, bx, ay, by;
	always_comb begin
		if (phase_q == PH_EP) begin
			ax = CURVE_W'(pt_x_q[0]);
			bx = CURVE_W'(pt_x_q[3]);
			ay = CURVE_W'(pt_y_q[0]);
			by = CURVE_W'(pt_y_q[3]);
		end else begin
			ax = cx_q;
			bx = CURVE_W'(qx_q);
			ay = cy_q;
			by = CURVE_W'(qy_q);
		end
	end

	logic emit_fire;
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_EP;
			out_valid_q <= 1'b0;
			lo_q        <= '0;
			hi_q        <= T_ONE;
			r_q         <= '0;
			rounds_q    <= '0;
			step_q      <= '0;
			dstep_q     <= '0;
			k_q         <= '0;
		end else begin
			if (emit_fire) out_valid_q <= 1'b1;
			else if (result_out.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (query_in.valid) begin
						qx_q      <= query_in.payload.query_x;
						qy_q      <= query_in.payload.query_y;
						pt_x_q[0] <= query_in.payload.start_x;
						pt_y_q[0] <= query_in.payload.start_y;
						pt_x_q[1] <= query_in.payload.ctrl0_x;
						pt_y_q[1] <= query_in.payload.ctrl0_y;
						pt_x_q[2] <= query_in.payload.ctrl1_x;
						pt_y_q[2] <= query_in.payload.ctrl1_y;
						pt_x_q[3] <= query_in.payload.end_x;
						pt_y_q[3] <= query_in.payload.end_y;
						state_q   <= S_BOX;
					end
				end
				S_BOX: begin
					rejected_q <= reject;
					lo_q       <= '0;
					hi_q       <= T_ONE;
					phase_q    <= PH_EP;
					dstep_q    <= '0;
					state_q    <= reject ? S_EMIT : S_DIST;
				end
				S_EVAL: begin
					step_q <= step_q + 4'd1;
					unique case (step_q)
						4'd1:  uu_q <= prnd;
						4'd2:  tt_q <= prnd;
						4'd3:  b_q[0] <= {1'b0, prnd};
						4'd4:  b_q[1] <= w3;
						4'd5:  b_q[2] <= w3;
						4'd6:  b_q[3] <= {1'b0, prnd};
						4'd7:  accx_q <= prod_e;
						4'd8, 4'd9, 4'd10: accx_q <= accx_q + prod_e;
						4'd11: begin
							accy_q <= prod_e;
							cx_q   <= rnd_s(accx_q);
						end
						4'd12, 4'd13, 4'd14: accy_q <= accy_q + prod_e;
						4'd15: begin
							cy_q    <= rnd_s(accy_q);
							dstep_q <= '0;
							state_q <= S_DIST;
						end
						default: ;
					endcase
				end
				S_DIST: begin
					dstep_q <= dstep_q + 2'd1;
					unique case (dstep_q)
						2'd0: begin
							dx_q <= MUL_W'(ax - bx);
							dy_q <= MUL_W'(ay - by);
						end
						2'd1: ;
						2'd2: d_q <= prod[DIST_W-1:0];
						2'd3: begin
							d_q     <= d_q + prod[DIST_W-1:0];
							state_q <= S_NEXT;
						end
						default: ;
					endcase
				end
				S_NEXT: begin
					unique case (phase_q)
						PH_EP: state_q <= S_EP_DIV;
						PH_SAMPLE: begin
							best_t_q <= best_t_n;
							best_d_q <= best_d_n;
							if (k_q == K_W'(SAMPLE_SLICES)) begin
								lo_q    <= lo_n;
								hi_q    <= hi_n;
								r_q     <= r_q + R_W'(1);
								state_q <= S_ROUND;
							end else begin
								k_q     <= k_q + K_W'(1);
								off_q   <= off_n;
								frac_q  <= frac_n;
								t_q     <= lo_q + off_n;
								step_q  <= '0;
								state_q <= S_EVAL;
							end
						end
						PH_FINAL: state_q <= S_EMIT;
						default: state_q <= S_EMIT;
					endcase
				end
				S_EP_DIV: begin
					if (div_done) begin
						rounds_q <= rounds_n;
						r_q      <= '0;
						state_q  <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (r_q < rounds_q && lo_q != hi_q) begin
						tick_q  <= w_scaled[2*PARAM_W-1:PARAM_W];
						state_q <= S_W_DIV;
					end else begin
						t_q     <= fin_sum[PARAM_W:1];
						phase_q <= PH_FINAL;
						step_q  <= '0;
						state_q <= S_EVAL;
					end
				end
				S_W_DIV: begin
					tick_q  <= tick_q + PARAM_W'(tick_fix);
					remv_q  <= rem_fix[FR_W-1:0];
					off_q   <= '0;
					frac_q  <= '0;
					k_q     <= '0;
					t_q     <= lo_q;
					phase_q <= PH_SAMPLE;
					step_q  <= '0;
					state_q <= S_EVAL;
				end
				S_EMIT: begin
					if (emit_fire) begin
						if (rejected_q) begin
							out_q <= '{is_near: 1'b0, box_rejected: 1'b1, best_param: '0,
								closest_x: '0, closest_y: '0};
						end else begin
							out_q <= '{is_near: d_q < DIST_W'(radius_q), box_rejected: 1'b0,
								best_param: t_q, closest_x: sat_coord(cx_q),
								closest_y: sat_coord(cy_q)};
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign query_in.ready     = (state_q == S_IDLE);
	assign result_out.valid   = out_valid_q;
	assign result_out.payload = out_q;

	a_interval_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q && hi_q <= T_ONE)
		else $error("search interval out of order");

	a_rounds_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		r_q <= R_W'(MAX_ITER) && rounds_q <= R_W'(MAX_ITER))
		else $error("round count beyond limit");

	a_reject_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.box_rejected |->
		!out_q.is_near && out_q.best_param == '0 && out_q.closest_x == '0 &&
		out_q.closest_y == '0)
		else $error("rejected result carries data");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		query_in.valid && query_in.ready |=> !query_in.ready)
		else $error("input taken while an item is in flight");
endmodule
